// ===== sv/adjacent_word_bigram_pairer_unit_macros.svh =====
// Assertion macros used by the checker file
`ifndef ADJACENT_WORD_BIGRAM_PAIRER_UNIT_MACROS_SVH
`define ADJACENT_WORD_BIGRAM_PAIRER_UNIT_MACROS_SVH
// Same-cycle implication, disabled in reset
`define AWBP_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lbl failed");
// Next-cycle implication, disabled in reset
`define AWBP_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lbl failed");
`endif

// ===== sv/awbp_pkg.sv =====
// Shared types and constants of the bigram pairer
package awbp_pkg;
    localparam logic [15:0] PSG_ALT = 16'd1000;
    localparam logic [10:0] SAT11 = 11'd2047;

    typedef struct packed {
        logic [15:0] psg;
        logic [15:0] word;
        logic [7:0]  len;
        logic [9:0]  idx;
    } slot_t;

    typedef struct packed {
        logic pair_hit;
        logic stale;
    } cmp_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_MREAD, ST_MCHK, ST_PREAD, ST_PCHK,
        ST_PMOVE, ST_ADD, ST_FLUSH, ST_TOTAL
    } state_t;
endpackage

// ===== sv/adjacent_word_bigram_pairer_unit.sv =====
// Top level of the adjacent-word bigram pairer
// A live posting past the first walks the candidate slots twice through one compare unit
// and a slot RAM with registered read: a match pass (read, compare per slot) and a prune
// pass (read, check, and for a removed slot that is not the last a move of the last slot
// into its place); a full table ends the walk in the match pass. The block takes no new
// item until it is done, and the output side can stall it. Pairs leave through one
// output register, one result held back so run_end can be marked.
module adjacent_word_bigram_pairer_unit #(
    parameter int TABLE_ENTRIES   = 1024,
    parameter int CANDIDATE_SLOTS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               first,
    input  logic               last,
    input  logic [10:0]        entry_count,
    input  logic [15:0]        psg_num,
    input  logic [15:0]        word_num,
    input  logic [7:0]         key_len,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               is_total,
    output logic [9:0]         pair_first_index,
    output logic [9:0]         pair_second_index,
    output logic [8:0]         joined_key_len,
    output logic signed [16:0] pair_passage_code,
    output logic [15:0]        pair_word_num,
    output logic [10:0]        total_count,
    output logic               run_end
);
    localparam int AW = $clog2(CANDIDATE_SLOTS);
    localparam int CW = $clog2(CANDIDATE_SLOTS + 1);

    awbp_pkg::state_t state_reg, state_next;
    logic [CW-1:0] sc_reg, sc_next, j_reg, j_next;
    logic [10:0]   ni_reg, ni_next, em_reg, em_next, idx_reg, idx_next;
    logic          full_reg, full_next;
    logic          last_reg, last_next;
    logic [10:0]   cnt_reg, cnt_next;
    logic [15:0]   psg_reg, psg_next, word_reg, word_next;
    logic [7:0]    len_reg, len_next;
    logic          pend_reg, pend_next;
    logic [9:0]    pend_idx_reg, pend_idx_next;
    logic [8:0]    pend_len_reg, pend_len_next;
    logic [15:0]   pend_word_reg, pend_word_next;
    logic          ov_reg, ov_next;
    logic          ot_reg, ot_next, oe_reg, oe_next;
    logic [9:0]    oa_reg, oa_next, ob_reg, ob_next;
    logic [8:0]    ol_reg, ol_next;
    logic [16:0]   op_reg, op_next;
    logic [15:0]   ow_reg, ow_next;
    logic [10:0]   oc_reg, oc_next;

    logic            wr_en, rd_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    awbp_pkg::slot_t wr_data, rd_data;
    awbp_pkg::cmp_t  cmp;

    logic        accept, out_free, full_hit, active, j_live, move_needed;
    logic [11:0] tot_sum;
    logic [10:0] base_ni;

    awbp_ram #(.WIDTH($bits(awbp_pkg::slot_t)), .DEPTH(CANDIDATE_SLOTS)) u_ram (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
    );

    awbp_cmp u_cmp (.slot(rd_data), .psg(psg_reg), .word(word_reg), .res(cmp));

    // Decode conditions
    always_comb
    begin
        accept      = in_valid && in_ready;
        out_free    = !ov_reg || out_ready;
        tot_sum     = {1'b0, cnt_reg} + {1'b0, em_reg};
        full_hit    = tot_sum >= 12'(TABLE_ENTRIES);
        active      = (cnt_reg >= 11'd2) && (idx_reg < cnt_reg) && !full_reg;
        j_live      = j_reg < sc_reg;
        move_needed = (j_reg + CW'(1)) < sc_reg;
        base_ni     = first ? 11'd0 : ni_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            awbp_pkg::ST_IDLE:  if (accept) state_next = awbp_pkg::ST_START;
            awbp_pkg::ST_START:
                if (active && idx_reg != 11'd0) state_next = awbp_pkg::ST_MREAD;
                else                            state_next = awbp_pkg::ST_FLUSH;
            awbp_pkg::ST_MREAD:
                if (!j_live)       state_next = awbp_pkg::ST_PREAD;
                else if (full_hit) state_next = awbp_pkg::ST_FLUSH;
                else               state_next = awbp_pkg::ST_MCHK;
            awbp_pkg::ST_MCHK:
                if (!cmp.pair_hit || !pend_reg || out_free)
                    state_next = awbp_pkg::ST_MREAD;
            awbp_pkg::ST_PREAD:
                state_next = j_live ? awbp_pkg::ST_PCHK : awbp_pkg::ST_ADD;
            awbp_pkg::ST_PCHK:
                state_next = (cmp.stale && move_needed) ? awbp_pkg::ST_PMOVE
                                                        : awbp_pkg::ST_PREAD;
            awbp_pkg::ST_PMOVE: state_next = awbp_pkg::ST_PREAD;
            awbp_pkg::ST_ADD:   state_next = awbp_pkg::ST_FLUSH;
            awbp_pkg::ST_FLUSH:
                if (!pend_reg || out_free)
                    state_next = last_reg ? awbp_pkg::ST_TOTAL : awbp_pkg::ST_IDLE;
            awbp_pkg::ST_TOTAL: if (out_free) state_next = awbp_pkg::ST_IDLE;
            default:            state_next = awbp_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        sc_next = sc_reg; j_next = j_reg; ni_next = ni_reg; em_next = em_reg;
        idx_next = idx_reg; full_next = full_reg; last_next = last_reg;
        cnt_next = cnt_reg; psg_next = psg_reg; word_next = word_reg; len_next = len_reg;
        pend_next = pend_reg; pend_idx_next = pend_idx_reg;
        pend_len_next = pend_len_reg; pend_word_next = pend_word_reg;
        ov_next = ov_reg && !out_ready;
        ot_next = ot_reg; oe_next = oe_reg; oa_next = oa_reg; ob_next = ob_reg;
        ol_next = ol_reg; op_next = op_reg; ow_next = ow_reg; oc_next = oc_reg;
        wr_en = 1'b0; wr_addr = j_reg[AW-1:0];
        wr_data = '{psg: psg_reg, word: word_reg, len: len_reg, idx: idx_reg[9:0]};
        rd_en = 1'b0; rd_addr = j_reg[AW-1:0];
        in_ready = (state_reg == awbp_pkg::ST_IDLE);

        unique case (state_reg)
            awbp_pkg::ST_IDLE:
                if (accept)
                begin
                    if (first)
                    begin
                        sc_next = '0; em_next = '0; full_next = 1'b0;
                    end
                    idx_next  = base_ni;
                    ni_next   = (base_ni < awbp_pkg::SAT11) ? base_ni + 11'd1 : base_ni;
                    last_next = last; cnt_next = entry_count;
                    psg_next  = psg_num; word_next = word_num; len_next = key_len;
                end
            awbp_pkg::ST_START:
            begin
                j_next = '0;
                if (active && idx_reg == 11'd0)
                begin
                    wr_en = 1'b1; wr_addr = '0; sc_next = CW'(1);
                end
            end
            awbp_pkg::ST_MREAD:
                if (j_live)
                begin
                    if (full_hit) full_next = 1'b1;
                    else          rd_en = 1'b1;
                end
                else
                begin
                    j_next = '0;
                end
            awbp_pkg::ST_MCHK:
                if (!cmp.pair_hit)
                begin
                    j_next = j_reg + CW'(1);
                end
                else if (!pend_reg || out_free)
                begin
                    // Push the held pair, hold the new one
                    if (pend_reg)
                    begin
                        ov_next = 1'b1; ot_next = 1'b0; oe_next = 1'b0;
                        oa_next = pend_idx_reg; ob_next = idx_reg[9:0];
                        ol_next = pend_len_reg; op_next = {1'b1, ~psg_reg};
                        ow_next = pend_word_reg; oc_next = '0;
                    end
                    pend_next      = 1'b1;
                    pend_idx_next  = rd_data.idx;
                    pend_len_next  = 9'({1'b0, rd_data.len} + {1'b0, len_reg} + 9'd1);
                    pend_word_next = rd_data.word;
                    em_next        = em_reg + 11'd1;
                    j_next         = j_reg + CW'(1);
                end
            awbp_pkg::ST_PREAD:
                if (j_live) rd_en = 1'b1;
            awbp_pkg::ST_PCHK:
                if (cmp.stale)
                begin
                    if (move_needed)
                    begin
                        rd_en = 1'b1; rd_addr = AW'(sc_reg - CW'(1));
                    end
                    else
                    begin
                        sc_next = sc_reg - CW'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            awbp_pkg::ST_PMOVE:
            begin
                // Drop slot j by moving the last slot into it
                wr_en = 1'b1; wr_data = rd_data; sc_next = sc_reg - CW'(1);
            end
            awbp_pkg::ST_ADD:
                if (sc_reg < CW'(CANDIDATE_SLOTS))
                begin
                    wr_en = 1'b1; wr_addr = sc_reg[AW-1:0]; sc_next = sc_reg + CW'(1);
                end
            awbp_pkg::ST_FLUSH:
                if (pend_reg && out_free)
                begin
                    ov_next = 1'b1; ot_next = 1'b0; oe_next = !last_reg;
                    oa_next = pend_idx_reg; ob_next = idx_reg[9:0];
                    ol_next = pend_len_reg; op_next = {1'b1, ~psg_reg};
                    ow_next = pend_word_reg; oc_next = '0;
                    pend_next = 1'b0;
                end
            awbp_pkg::ST_TOTAL:
                if (out_free)
                begin
                    ov_next = 1'b1; ot_next = 1'b1; oe_next = 1'b1;
                    oa_next = '0; ob_next = '0; ol_next = '0; op_next = '0; ow_next = '0;
                    oc_next = (tot_sum > {1'b0, awbp_pkg::SAT11}) ? awbp_pkg::SAT11
                                                                  : tot_sum[10:0];
                end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= awbp_pkg::ST_IDLE;
            sc_reg <= '0; ni_reg <= '0; em_reg <= '0; full_reg <= 1'b0;
            pend_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sc_reg <= sc_next; ni_reg <= ni_next; em_reg <= em_next;
            full_reg <= full_next; pend_reg <= pend_next; ov_reg <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        j_reg <= j_next; idx_reg <= idx_next; last_reg <= last_next; cnt_reg <= cnt_next;
        psg_reg <= psg_next; word_reg <= word_next; len_reg <= len_next;
        pend_idx_reg <= pend_idx_next; pend_len_reg <= pend_len_next;
        pend_word_reg <= pend_word_next;
        ot_reg <= ot_next; oe_reg <= oe_next; oa_reg <= oa_next; ob_reg <= ob_next;
        ol_reg <= ol_next; op_reg <= op_next; ow_reg <= ow_next; oc_reg <= oc_next;
    end

    assign out_valid         = ov_reg;
    assign is_total          = ot_reg;
    assign pair_first_index  = oa_reg;
    assign pair_second_index = ob_reg;
    assign joined_key_len    = ol_reg;
    assign pair_passage_code = op_reg;
    assign pair_word_num     = ow_reg;
    assign total_count       = oc_reg;
    assign run_end           = oe_reg;
endmodule

// ===== sv/awbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module awbp_ram #(
    parameter int WIDTH = 50,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== sv/awbp_cmp.sv =====
// Slot compare unit: adjacency match and staleness of one candidate
module awbp_cmp (
    input  awbp_pkg::slot_t slot,
    input  logic [15:0]     psg,
    input  logic [15:0]     word,
    output awbp_pkg::cmp_t  res
);
    logic        psg_eq;
    logic        psg_alt;
    logic [16:0] slot_word_inc;

    always_comb
    begin
        psg_eq        = (slot.psg == psg);
        psg_alt       = ((slot.psg == 16'd0) && (psg == awbp_pkg::PSG_ALT))
                     || ((slot.psg == awbp_pkg::PSG_ALT) && (psg == 16'd0));
        slot_word_inc = {1'b0, slot.word} + 17'd1;
        res.pair_hit  = (psg_eq || psg_alt) && (slot_word_inc == {1'b0, word});
        res.stale     = psg_eq && (slot_word_inc < {1'b0, word});
    end
endmodule

// ===== sv/awbp_checker.sv =====
// Port-level checker of the bigram pairer and its bind
`include "adjacent_word_bigram_pairer_unit_macros.svh"
module awbp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        is_total,
    input logic [10:0] total_count,
    input logic [16:0] pair_passage_code,
    input logic        run_end
);
    `AWBP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `AWBP_ASSERT_NEXT(a_busy_after_item, clk, rst_n, in_valid && in_ready, !in_ready)
    `AWBP_ASSERT_NOW(a_total_ends_run, clk, rst_n, out_valid && is_total, run_end)
    `AWBP_ASSERT_NOW(a_pair_shape, clk, rst_n, out_valid && !is_total,
                     total_count == 11'd0 && pair_passage_code[16])
endmodule

bind adjacent_word_bigram_pairer_unit awbp_checker u_awbp_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .is_total(is_total),
    .total_count(total_count), .pair_passage_code(pair_passage_code), .run_end(run_end)
);

// ===== tb/sv/tb_adjacent_word_bigram_pairer_unit.sv =====
// Testbench for the adjacent-word bigram pairer: random and directed postings, scoreboard check
`timescale 1ns / 1ps

module tb_adjacent_word_bigram_pairer_unit;
    localparam int TABLE_SIZE  = 1024;
    localparam int SLOT_DEPTH  = 32;
    localparam int STALL_LIMIT = 20000;
    localparam int RAND_ITEMS  = 420;

    typedef struct {
        bit        tot;
        bit [9:0]  a;
        bit [9:0]  b;
        bit [8:0]  jl;
        bit [16:0] pc;
        bit [15:0] wn;
        bit [10:0] tc;
        bit        re;
    } bigram_res_t;

    // Track candidate slots and the pairs each posting should produce
    class bigram_scoreboard;
        bit [15:0] s_psg [SLOT_DEPTH];
        bit [15:0] s_word[SLOT_DEPTH];
        bit [7:0]  s_len [SLOT_DEPTH];
        bit [9:0]  s_idx [SLOT_DEPTH];
        int  live;
        int  nidx;
        int  made;
        bit  full;
        int  errors;
        int  pairs_seen;
        int  totals_seen;
        bigram_res_t pending[$];

        function bit psg_eq(bit [15:0] x, bit [15:0] y);
            return x == y || (x == 0 && y == 1000) || (x == 1000 && y == 0);
        endfunction

        function void note_input(bit f, bit l, bit [10:0] cnt, bit [15:0] psg,
                                 bit [15:0] word, bit [7:0] klen);
            int idx;
            int j;
            int first_res;
            bit stop;
            bigram_res_t r;
            first_res = pending.size();
            if (f)
            begin
                live = 0; nidx = 0; made = 0; full = 0;
            end
            idx = nidx;
            if (nidx < 2047) nidx++;
            if (cnt >= 2 && idx < cnt && !full)
            begin
                if (idx == 0)
                begin
                    s_psg[0] = psg; s_word[0] = word; s_len[0] = klen; s_idx[0] = 0;
                    live = 1;
                end
                else
                begin
                    stop = 0;
                    // walk slots in order, emit pairs for adjacent words
                    for (j = 0; j < live; j++)
                    begin
                        if (int'(cnt) + made >= TABLE_SIZE)
                        begin
                            full = 1; stop = 1;
                            break;
                        end
                        if (psg_eq(s_psg[j], psg) && int'(s_word[j]) + 1 == int'(word))
                        begin
                            r = '{0, s_idx[j], idx[9:0], 9'(s_len[j] + klen + 1),
                                  {1'b1, ~psg}, s_word[j], 0, 0};
                            pending.push_back(r);
                            made++;
                        end
                    end
                    if (!stop)
                    begin
                        // drop stale slots of this passage, swap in the last one
                        j = 0;
                        while (j < live)
                        begin
                            if (s_psg[j] == psg && int'(s_word[j]) + 1 < int'(word))
                            begin
                                if (j + 1 < live)
                                begin
                                    s_psg[j] = s_psg[live-1]; s_word[j] = s_word[live-1];
                                    s_len[j] = s_len[live-1]; s_idx[j] = s_idx[live-1];
                                end
                                live--;
                            end
                            else
                                j++;
                        end
                        if (live < SLOT_DEPTH)
                        begin
                            s_psg[live] = psg; s_word[live] = word;
                            s_len[live] = klen; s_idx[live] = idx[9:0];
                            live++;
                        end
                    end
                end
            end
            if (l)
            begin
                r = '{1, 0, 0, 0, 0, 0, 0, 0};
                r.tc = (int'(cnt) + made > 2047) ? 11'd2047 : 11'(int'(cnt) + made);
                pending.push_back(r);
            end
            if (pending.size() > first_res) pending[pending.size()-1].re = 1;
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        task check(bigram_res_t got);
            bigram_res_t w;
            if (pending.size() == 0)
            begin
                report("result with nothing expected");
                return;
            end
            w = pending.pop_front();
            if (got.tot) totals_seen++; else pairs_seen++;
            if (got != w)
                report($sformatf("got %0d %0d %0d %0d %h %0d %0d %0d exp %0d %0d %0d %0d %h %0d %0d %0d",
                    got.tot, got.a, got.b, got.jl, got.pc, got.wn, got.tc, got.re,
                    w.tot, w.a, w.b, w.jl, w.pc, w.wn, w.tc, w.re));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               first;
    logic               last;
    logic [10:0]        entry_count;
    logic [15:0]        psg_num;
    logic [15:0]        word_num;
    logic [7:0]         key_len;
    logic               out_valid;
    logic               out_ready;
    logic               is_total;
    logic [9:0]         pair_first_index;
    logic [9:0]         pair_second_index;
    logic [8:0]         joined_key_len;
    logic signed [16:0] pair_passage_code;
    logic [15:0]        pair_word_num;
    logic [10:0]        total_count;
    logic               run_end;

    bigram_scoreboard sb;
    bit  gaps_on;
    int  sent;
    int  stall_cycles;
    int  out_burst;

    adjacent_word_bigram_pairer_unit u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .first(first), .last(last), .entry_count(entry_count), .psg_num(psg_num),
        .word_num(word_num), .key_len(key_len), .out_valid(out_valid),
        .out_ready(out_ready), .is_total(is_total), .pair_first_index(pair_first_index),
        .pair_second_index(pair_second_index), .joined_key_len(joined_key_len),
        .pair_passage_code(pair_passage_code), .pair_word_num(pair_word_num),
        .total_count(total_count), .run_end(run_end)
    );

    always
    begin
        clk = 1'b1; #1;
        clk = 1'b0; #1;
    end

    // Offer one posting, optionally after an idle burst, and hold until accepted
    task send_item(bit f, bit l, bit [10:0] cnt, bit [15:0] p, bit [15:0] w, bit [7:0] k);
        int n;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            n = $urandom_range(1, 14);
            repeat (n) @(negedge clk);
        end
        first = f; last = l; entry_count = cnt; psg_num = p; word_num = w; key_len = k;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(f, l, cnt, p, w, k);
        sent++;
        @(negedge clk);
    endtask

    // Build one list of postings with mostly adjacent words in a few passages
    task rand_list();
        int len;
        int cnt;
        int np;
        int i;
        int s;
        bit [15:0] pool[4];
        bit [15:0] wpos[4];
        bit [15:0] w;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 45) : $urandom_range(2, 14);
        case ($urandom_range(0, 9))
            0: cnt = $urandom_range(0, 1);
            1: cnt = $urandom_range(1000, 1024);
            2: cnt = $urandom_range(1, len);
            default: cnt = len;
        endcase
        np = (len > 30) ? 4 : $urandom_range(1, 4);
        for (i = 0; i < 4; i++)
        begin
            case ($urandom_range(0, 3))
                0: pool[i] = 16'd0;
                1: pool[i] = 16'd1000;
                2: pool[i] = 16'($urandom_range(1, 20));
                default: pool[i] = 16'($urandom);
            endcase
            wpos[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        end
        for (i = 0; i < len; i++)
        begin
            s = $urandom_range(0, np - 1);
            if (len > 30) s = i % 4;
            case ($urandom_range(0, 9))
                0: w = 16'($urandom);
                1: w = wpos[s] + 16'd2;
                2: w = wpos[s];
                default: w = (len > 30 && i >= 4) ? wpos[s] + 16'd5 : wpos[s] + 16'd1;
            endcase
            if (len > 30) pool[s] = pool[s] + 16'(i);
            wpos[s] = w;
            send_item((i == 0) && ($urandom_range(0, 15) != 0),
                      (i == len - 1) || ($urandom_range(0, 15) == 0),
                      11'(cnt), pool[s], w, 8'($urandom));
        end
    endtask

    // Drive out_ready with random stall bursts while gaps are enabled
    always @(negedge clk)
    begin
        if (!gaps_on)
            out_ready = 1'b1;
        else if (out_burst > 0)
            out_burst--;
        else
        begin
            out_ready = ($urandom_range(0, 2) != 0);
            out_burst = $urandom_range(1, 14);
        end
    end

    // Check every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check('{is_total, pair_first_index, pair_second_index, joined_key_len,
                       pair_passage_code, pair_word_num, total_count, run_end});
    end

    // Stop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        gaps_on = 1'b1;
        sent = 0;
        stall_cycles = 0;
        out_burst = 0;
        rst_n = 1'b0;
        in_valid = 1'b0; out_ready = 1'b0;
        first = 1'b0; last = 1'b0; entry_count = '0;
        psg_num = '0; word_num = '0; key_len = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // short list gives only the total
        send_item(1'b1, 1'b0, 11'd1, 16'd5, 16'd10, 8'd3);
        send_item(1'b0, 1'b1, 11'd1, 16'd5, 16'd11, 8'd4);
        // passages 0 and 1000 pair, extreme key lengths
        send_item(1'b1, 1'b0, 11'd4, 16'd0, 16'd65534, 8'd255);
        send_item(1'b0, 1'b0, 11'd4, 16'd1000, 16'd65535, 8'd255);
        send_item(1'b0, 1'b0, 11'd4, 16'd1000, 16'd3, 8'd0);
        send_item(1'b0, 1'b1, 11'd4, 16'd0, 16'd4, 8'd7);
        // items past the list end
        send_item(1'b1, 1'b0, 11'd2, 16'd65535, 16'd0, 8'd1);
        send_item(1'b0, 1'b0, 11'd2, 16'd65535, 16'd1, 8'd2);
        send_item(1'b0, 1'b0, 11'd2, 16'd65535, 16'd2, 8'd3);
        send_item(1'b0, 1'b1, 11'd2, 16'd65535, 16'd3, 8'd4);
        // table already full
        send_item(1'b1, 1'b0, 11'd1024, 16'd9, 16'd1, 8'd1);
        send_item(1'b0, 1'b0, 11'd1024, 16'd9, 16'd2, 8'd1);
        send_item(1'b0, 1'b1, 11'd1024, 16'd9, 16'd3, 8'd1);
        // table fills after a few pairs
        send_item(1'b1, 1'b0, 11'd1022, 16'd2, 16'd1, 8'd9);
        send_item(1'b0, 1'b0, 11'd1022, 16'd2, 16'd2, 8'd9);
        send_item(1'b0, 1'b0, 11'd1022, 16'd2, 16'd3, 8'd9);
        send_item(1'b0, 1'b0, 11'd1022, 16'd2, 16'd4, 8'd9);
        send_item(1'b0, 1'b1, 11'd1022, 16'd2, 16'd5, 8'd9);

        while (sent < RAND_ITEMS)
        begin
            if (sent > RAND_ITEMS - 60) gaps_on = 1'b0;
            rand_list();
        end
        in_valid = 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        $display("covered %0d pairs and %0d totals across directed and random lists",
                 sb.pairs_seen, sb.totals_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
